### hdl/exfat_des_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the exFAT directory entry set parser.
// No dependencies; imported by exfat_dir_entry_set_parser_core.
package exfat_des_pkg;

    // Record kinds on the result stream
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_SET  = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // Entry type codes and byte offsets inside a 32-byte entry
    localparam logic [7:0] TYPE_FILE       = 8'h85;
    localparam logic [7:0] TYPE_END        = 8'h00;
    localparam logic [7:0] ATTR_DIR_MASK   = 8'h10;  // low byte of attribute word
    localparam logic [4:0] OFS_TYPE        = 5'd0;
    localparam logic [4:0] OFS_NAME_LEN    = 5'd3;
    localparam logic [4:0] OFS_ATTR        = 5'd4;
    localparam logic [4:0] OFS_ENTRY_LAST  = 5'd31;
    localparam logic [3:0] CHARS_PER_ENTRY = 4'd15;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [7:0]  name_char;
        logic        dir_attr;
        logic [31:0] start_cluster;
        logic [63:0] byte_length;
        logic [7:0]  name_chars;
        logic        last_of_run;
    } result_t;

endpackage

### hdl/exfat_dir_entry_set_parser_core.sv
`timescale 1ns / 1ps
// exFAT directory entry set parser: byte-stream parse of file entry sets.
// Depends on exfat_des_pkg (result type, kind codes, entry constants).

// Takes one directory byte per clock on the s_ side and returns name
// characters, set descriptors and end-of-directory records on the m_ side,
// one record per word. An accepted byte is held in an input register,
// parsed there by a single level of field-capture logic, and its zero, one
// or two records are written into a small result queue of FIFO_DEPTH
// words that drives the m_ port directly. The first record of a byte thus
// passes the input register and the queue before it shows on m_tvalid.
// Bytes are taken every cycle as long as the queue has room for the
// records of both the byte in the input register and the next one; with
// a FIFO_DEPTH of 8 or more and a sink that takes a word every cycle this
// never stalls, since only a set descriptor or a name character followed
// by an end record makes two records from one byte. The parse restarts on a
// byte with s_tuser (first of directory) set; after an end record all bytes
// are dropped until such a byte arrives. A set cut off by s_tlast emits no
// descriptor, only the end record.
module exfat_dir_entry_set_parser_core
    import exfat_des_pkg::*;
#(
    parameter int FIFO_DEPTH = 8   // power of two, at least 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] dir_byte
    input  logic         s_tuser,   // [0] first_of_directory
    input  logic         s_tlast,   // last_of_directory
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // [7:0] name_char, [8] dir_attr,
                                    // [40:9] start_cluster, [104:41] byte_length,
                                    // [112:105] name_chars, [119:113] zero
    output logic [1:0]   m_tuser,   // [1:0] record_kind
    output logic         m_tlast    // last_of_run
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_FILE,
        PH_STREAM,
        PH_NAME,
        PH_DONE
    } phase_t;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       in_last_reg;

    // Parse state
    phase_t      phase_reg,    phase_next;
    logic [4:0]  pos_reg,      pos_next;
    logic        dir_flag_reg, dir_flag_next;
    logic [7:0]  name_len_reg, name_len_next;
    logic [7:0]  rem_reg,      rem_next;
    logic [31:0] clus_reg,     clus_next;
    logic [63:0] dlen_reg,     dlen_next;

    // Records produced by the byte in the input register
    result_t    res0, res1;
    logic [1:0] res_n;

    // Result queue
    result_t            queue_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W:0]     room_need;
    logic               pop;

    // Leave room for the pending byte and the one accepted now
    assign room_need = {1'b0, count_reg}
                     + (in_valid_reg ? (CNT_W+1)'(4) : (CNT_W+1)'(2));
    assign s_tready  = room_need <= (CNT_W+1)'(FIFO_DEPTH);

    assign m_tvalid = count_reg != '0;
    assign pop      = m_tvalid && m_tready;
    assign m_tuser  = queue_mem[rd_ptr_reg].record_kind;
    assign m_tlast  = queue_mem[rd_ptr_reg].last_of_run;
    assign m_tdata  = {7'b0,
                       queue_mem[rd_ptr_reg].name_chars,
                       queue_mem[rd_ptr_reg].byte_length,
                       queue_mem[rd_ptr_reg].start_cluster,
                       queue_mem[rd_ptr_reg].dir_attr,
                       queue_mem[rd_ptr_reg].name_char};

    // Parse one byte: field capture and record build
    always_comb begin
        phase_t     ph;
        logic [4:0] pos;
        logic [3:0] here;
        logic [3:0] char_idx;
        logic       emit_char;
        logic       emit_set;
        logic       emit_end;
        result_t    rec_char;
        result_t    rec_set;
        result_t    rec_end;

        // A first-of-directory byte restarts from the reset state
        ph            = in_first_reg ? PH_SEARCH : phase_reg;
        pos           = in_first_reg ? 5'd0  : pos_reg;
        dir_flag_next = in_first_reg ? 1'b0  : dir_flag_reg;
        name_len_next = in_first_reg ? 8'd0  : name_len_reg;
        rem_next      = in_first_reg ? 8'd0  : rem_reg;
        clus_next     = in_first_reg ? 32'd0 : clus_reg;
        dlen_next     = in_first_reg ? 64'd0 : dlen_reg;
        phase_next    = ph;
        pos_next      = pos;
        emit_char     = 1'b0;
        emit_set      = 1'b0;
        emit_end      = 1'b0;
        here          = (rem_next < 8'(CHARS_PER_ENTRY)) ? rem_next[3:0] : CHARS_PER_ENTRY;
        char_idx      = pos[4:1] - 4'd1;

        if (ph != PH_DONE) begin
            case (ph)
                PH_SEARCH: begin
                    if (pos == OFS_TYPE && in_byte_reg == TYPE_END) begin
                        emit_end   = 1'b1;
                        phase_next = PH_DONE;
                    end else if (pos == OFS_TYPE && in_byte_reg == TYPE_FILE) begin
                        phase_next = PH_FILE;
                    end
                end
                PH_FILE: begin
                    if (pos == OFS_ATTR) begin
                        dir_flag_next = (in_byte_reg & ATTR_DIR_MASK) != 8'd0;
                    end
                    if (pos == OFS_ENTRY_LAST) begin
                        phase_next = PH_STREAM;
                    end
                end
                PH_STREAM: begin
                    if (pos == OFS_NAME_LEN) begin
                        name_len_next = in_byte_reg;
                    end else if (pos inside {[5'd20:5'd23]}) begin
                        clus_next[8*pos[1:0] +: 8] = in_byte_reg;
                    end else if (pos inside {[5'd24:5'd31]}) begin
                        dlen_next[8*pos[2:0] +: 8] = in_byte_reg;
                    end
                    if (pos == OFS_ENTRY_LAST) begin
                        rem_next = name_len_next;
                        if (name_len_next == 8'd0) begin
                            emit_set   = 1'b1;
                            phase_next = PH_SEARCH;
                        end else begin
                            phase_next = PH_NAME;
                        end
                    end
                end
                PH_NAME: begin
                    emit_char = (pos != 5'd0) && !pos[0] && (char_idx < here);
                    if (pos == OFS_ENTRY_LAST) begin
                        rem_next = rem_next - {4'd0, here};
                        if (rem_next == 8'd0) begin
                            emit_set   = 1'b1;
                            phase_next = PH_SEARCH;
                        end
                    end
                end
                default: begin
                    phase_next = PH_SEARCH;
                end
            endcase
            pos_next = pos + 5'd1;
            // Out of data: close with an end record after anything else
            if (in_last_reg && phase_next != PH_DONE) begin
                emit_end   = 1'b1;
                phase_next = PH_DONE;
            end
        end

        rec_char             = '0;
        rec_char.record_kind = KIND_CHAR;
        rec_char.name_char   = in_byte_reg;

        rec_set               = '0;
        rec_set.record_kind   = KIND_SET;
        rec_set.dir_attr      = dir_flag_next;
        rec_set.start_cluster = clus_next;
        rec_set.byte_length   = dlen_next;
        rec_set.name_chars    = name_len_next;

        rec_end             = '0;
        rec_end.record_kind = KIND_END;

        // Order: character, then descriptor, then end record
        res0  = '0;
        res1  = rec_end;
        res_n = 2'd0;
        if (emit_char && emit_set) begin
            res0  = rec_char;
            res1  = rec_set;
            res_n = 2'd2;
        end else if (emit_char || emit_set) begin
            res0  = emit_char ? rec_char : rec_set;
            res_n = emit_end ? 2'd2 : 2'd1;
        end else if (emit_end) begin
            res0  = rec_end;
            res_n = 2'd1;
        end
        if (res_n == 2'd1) begin
            res0.last_of_run = 1'b1;
        end else if (res_n == 2'd2) begin
            res1.last_of_run = 1'b1;
        end

        if (!in_valid_reg) begin
            res_n = 2'd0;
        end
    end

    // Input register, parse state and queue control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_SEARCH;
            pos_reg      <= 5'd0;
            dir_flag_reg <= 1'b0;
            name_len_reg <= 8'd0;
            rem_reg      <= 8'd0;
            clus_reg     <= 32'd0;
            dlen_reg     <= 64'd0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end else begin
            in_valid_reg <= s_tvalid && s_tready;
            if (in_valid_reg) begin
                phase_reg    <= phase_next;
                pos_reg      <= pos_next;
                dir_flag_reg <= dir_flag_next;
                name_len_reg <= name_len_next;
                rem_reg      <= rem_next;
                clus_reg     <= clus_next;
                dlen_reg     <= dlen_next;
            end
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(res_n);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(res_n) - CNT_W'(pop);
        end
    end

    // Input payload and queue storage
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
        if (res_n != 2'd0) begin
            queue_mem[wr_ptr_reg] <= res0;
        end
        if (res_n == 2'd2) begin
            queue_mem[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    // Queue never overfills
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue count above depth");

    // A pending byte always finds room for two records
    a_room_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg |-> count_reg <= CNT_W'(FIFO_DEPTH - 2))
        else $error("pending byte without queue room");

    // After the end record, bytes without a restart produce nothing
    a_done_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DONE && !in_first_reg) |-> res_n == 2'd0)
        else $error("record produced after end of directory");

    // A second record from one byte is a descriptor or an end record
    a_second_rec: assert property (@(posedge aclk) disable iff (!aresetn)
        res_n == 2'd2 |-> (res1.record_kind == KIND_END || res1.record_kind == KIND_SET))
        else $error("unexpected second record kind");

    // A pop with no push shrinks the queue by one
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && res_n == 2'd0) |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("queue count not decremented on pop");

endmodule
